[hdl/prb_pkg.sv]
// Shared types and constants for the packet ring buffer.
// No dependencies; used by the core and by its port checker.
package prb_pkg;

  // Configuration register and ring size widths
  localparam int ACTIVE_W = 4;
  localparam int SIZE_W = ACTIVE_W + 1;
  localparam int MAX_RING = 1 << ACTIVE_W;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd15;

  // Result field widths that are fixed by the interface
  localparam int LEN_W = 7;
  localparam int PCT_W = 7;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t STATUS_OK = 3'd0;
  localparam status_t STATUS_EMPTY = 3'd1;
  localparam status_t STATUS_TOO_SMALL = 3'd2;
  localparam status_t STATUS_TRUNCATED = 3'd3;
  localparam status_t STATUS_OVERWRITTEN = 3'd4;

  // Fill percent: count * 100 / n as (count * ceil(100 * 2^16 / n)) >> 16.
  // Exact for count < n <= 16.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W = 22;
  localparam logic [RECIP_W-1:0] PCT_RECIP [MAX_RING+1] = '{
    22'd0,
    22'd0,
    22'((100 * 65536 + 1) / 2),
    22'((100 * 65536 + 2) / 3),
    22'((100 * 65536 + 3) / 4),
    22'((100 * 65536 + 4) / 5),
    22'((100 * 65536 + 5) / 6),
    22'((100 * 65536 + 6) / 7),
    22'((100 * 65536 + 7) / 8),
    22'((100 * 65536 + 8) / 9),
    22'((100 * 65536 + 9) / 10),
    22'((100 * 65536 + 10) / 11),
    22'((100 * 65536 + 11) / 12),
    22'((100 * 65536 + 12) / 13),
    22'((100 * 65536 + 13) / 14),
    22'((100 * 65536 + 14) / 15),
    22'((100 * 65536 + 15) / 16)
  };

endpackage

[hdl/packet_ring_buffer_core.sv]
// Packet ring buffer core: slot memories, pointers and result sequencer.
// Depends on prb_pkg.
//
// A ring of (active_slots + 1) packet slots with one slot kept empty.
// Packet bytes live in a single-port-write, registered-read byte memory;
// length, flags and timestamp of each slot live in a second memory of the
// same kind. A write updates the memories and pointers at acceptance;
// its result is loaded into the output register from the result state.
// A read of a stored packet fetches the slot metadata and first byte at
// acceptance, checks the capacity in the metadata state, then streams one
// byte per cycle while the output is not stalled. A read on an empty ring
// or a too-small read gives a single result. A new request is taken once
// the previous one has handed its last result to the output register,
// even if that result has not yet been taken downstream. Writing
// active_slots empties the ring; no clearing pass is needed after reset.
module packet_ring_buffer_core #(
  parameter int RING_SLOTS = 16,
  parameter int SLOT_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [prb_pkg::ACTIVE_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [7:0]                    in_byte,
  input  logic                          in_byte_valid,
  input  logic                          end_of_packet,
  input  logic [31:0]                   packet_flags,
  input  logic signed [63:0]            packet_time,
  input  logic [15:0]                   read_capacity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_byte_valid,
  output logic                          last_of_run,
  output logic [prb_pkg::LEN_W-1:0]     out_length,
  output logic [31:0]                   out_flags,
  output logic signed [63:0]            out_time,
  output prb_pkg::status_t              status,
  output logic [prb_pkg::PCT_W-1:0]     fill_percent,
  output logic                          ring_empty,
  output logic                          ring_full
);

  // Only as many slots as the register can address are ever used
  localparam int USED_SLOTS = (RING_SLOTS < prb_pkg::MAX_RING) ? RING_SLOTS : prb_pkg::MAX_RING;
  localparam int SLOT_W = $clog2(USED_SLOTS);
  localparam int OFF_W = $clog2(SLOT_BYTES + 1);
  localparam int BIDX_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int BYTE_DEPTH = USED_SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(BYTE_DEPTH);
  localparam int MAX_ACTIVE = USED_SLOTS - 1;
  localparam int META_W = OFF_W + 32 + 64;
  localparam int PROD_W = prb_pkg::ACTIVE_W + prb_pkg::RECIP_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESULT = 2'd1;
  localparam logic [1:0] S_META = 2'd2;
  localparam logic [1:0] S_STREAM = 2'd3;

  logic [1:0]                   state;
  logic [prb_pkg::ACTIVE_W-1:0] active_slots;
  logic [SLOT_W-1:0]            write_slot;
  logic [SLOT_W-1:0]            read_slot;
  logic [SLOT_W-1:0]            cur_slot;
  logic [OFF_W-1:0]             write_offset;
  logic [BIDX_W-1:0]            rd_idx;
  logic [15:0]                  capacity;
  prb_pkg::status_t             res_status;

  logic [7:0]        byte_mem [BYTE_DEPTH];
  logic [7:0]        byte_rd;
  logic [META_W-1:0] meta_mem [USED_SLOTS];
  logic [META_W-1:0] meta_rd;

  logic [prb_pkg::ACTIVE_W-1:0] active_eff;
  logic [prb_pkg::SIZE_W-1:0]   ring_n;
  logic [prb_pkg::SIZE_W-1:0]   ws_inc;
  logic [prb_pkg::SIZE_W-1:0]   rs_inc;
  logic [SLOT_W-1:0]            ws_adv;
  logic [SLOT_W-1:0]            rs_adv;
  logic                         empty_now;
  logic                         full_now;
  logic [prb_pkg::SIZE_W-1:0]   diff;
  logic [PROD_W-1:0]            pct_prod;

  logic                    accept;
  logic                    out_free;
  logic                    byte_take;
  logic [OFF_W-1:0]        wo_after;
  prb_pkg::status_t        wr_status;
  logic [ADDR_W-1:0]       byte_waddr;
  logic [ADDR_W-1:0]       byte_raddr;
  logic                    byte_we;
  logic                    byte_re;
  logic                    meta_we;
  logic                    meta_re;
  logic [OFF_W-1:0]        meta_len;
  logic [31:0]             meta_flags;
  logic [63:0]             meta_time;
  logic                    too_small;
  logic                    stream_last;

  logic                    out_load;
  logic [7:0]              ld_byte;
  logic                    ld_bvalid;
  logic                    ld_last;
  logic [OFF_W-1:0]        ld_len;
  logic [31:0]             ld_flags;
  logic [63:0]             ld_time;
  prb_pkg::status_t        ld_status;

  // Ring size from the register, clamped to the usable range
  always_comb begin
    if (active_slots == '0) begin
      active_eff = prb_pkg::ACTIVE_W'(1);
    end else if (active_slots > prb_pkg::ACTIVE_W'(MAX_ACTIVE)) begin
      active_eff = prb_pkg::ACTIVE_W'(MAX_ACTIVE);
    end else begin
      active_eff = active_slots;
    end
  end

  assign ring_n = prb_pkg::SIZE_W'(active_eff) + prb_pkg::SIZE_W'(1);

  // Pointer advance with wrap at the ring size
  assign ws_inc = prb_pkg::SIZE_W'(write_slot) + prb_pkg::SIZE_W'(1);
  assign rs_inc = prb_pkg::SIZE_W'(read_slot) + prb_pkg::SIZE_W'(1);
  assign ws_adv = (ws_inc == ring_n) ? '0 : ws_inc[SLOT_W-1:0];
  assign rs_adv = (rs_inc == ring_n) ? '0 : rs_inc[SLOT_W-1:0];

  assign empty_now = (write_slot == read_slot);
  assign full_now = (ws_adv == read_slot);

  // Stored packet count and fill percent
  always_comb begin
    if (write_slot >= read_slot) begin
      diff = prb_pkg::SIZE_W'(write_slot) - prb_pkg::SIZE_W'(read_slot);
    end else begin
      diff = prb_pkg::SIZE_W'(write_slot) + ring_n - prb_pkg::SIZE_W'(read_slot);
    end
  end

  assign pct_prod = PROD_W'(diff[prb_pkg::ACTIVE_W-1:0]) *
                    PROD_W'(prb_pkg::PCT_RECIP[ring_n]);

  // Handshake
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Write request decode
  assign byte_take = in_byte_valid && (write_offset < OFF_W'(SLOT_BYTES));
  assign wo_after = byte_take ? write_offset + OFF_W'(1) : write_offset;

  always_comb begin
    if (end_of_packet && full_now) begin
      wr_status = prb_pkg::STATUS_OVERWRITTEN;
    end else if (in_byte_valid && !byte_take) begin
      wr_status = prb_pkg::STATUS_TRUNCATED;
    end else begin
      wr_status = prb_pkg::STATUS_OK;
    end
  end

  // Memory addressing and enables
  assign byte_waddr = ADDR_W'(write_slot) * ADDR_W'(SLOT_BYTES) +
                      ADDR_W'(write_offset[BIDX_W-1:0]);

  always_comb begin
    if (state == S_STREAM) begin
      byte_raddr = ADDR_W'(cur_slot) * ADDR_W'(SLOT_BYTES) +
                   ADDR_W'(rd_idx + BIDX_W'(1));
    end else begin
      byte_raddr = ADDR_W'(read_slot) * ADDR_W'(SLOT_BYTES);
    end
  end

  assign byte_we = accept && (operation == prb_pkg::OP_WRITE) && byte_take;
  assign meta_we = accept && (operation == prb_pkg::OP_WRITE) && end_of_packet;
  assign meta_re = accept && (operation == prb_pkg::OP_READ) && !empty_now;
  assign byte_re = meta_re || ((state == S_STREAM) && out_free && !stream_last);

  // Byte store
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= in_byte;
    end
    if (byte_re) begin
      byte_rd <= byte_mem[byte_raddr];
    end
  end

  // Slot metadata store: {length, flags, time}
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[write_slot] <= {wo_after, packet_flags, packet_time};
    end
    if (meta_re) begin
      meta_rd <= meta_mem[read_slot];
    end
  end

  assign meta_len = meta_rd[META_W-1 -: OFF_W];
  assign meta_flags = meta_rd[95:64];
  assign meta_time = meta_rd[63:0];
  assign too_small = (meta_len == '0) || (capacity < 16'(meta_len));
  assign stream_last = ((OFF_W'(rd_idx) + OFF_W'(1)) == meta_len);

  // Result selection per state
  always_comb begin
    out_load = 1'b0;
    ld_byte = '0;
    ld_bvalid = 1'b0;
    ld_last = 1'b1;
    ld_len = '0;
    ld_flags = '0;
    ld_time = '0;
    ld_status = res_status;
    unique case (state)
      S_IDLE: begin
        out_load = 1'b0;
      end
      S_RESULT: begin
        out_load = out_free;
      end
      S_META: begin
        out_load = out_free && too_small;
        ld_len = meta_len;
        ld_flags = meta_flags;
        ld_time = meta_time;
        ld_status = prb_pkg::STATUS_TOO_SMALL;
      end
      S_STREAM: begin
        out_load = out_free;
        ld_byte = byte_rd;
        ld_bvalid = 1'b1;
        ld_last = stream_last;
        ld_len = meta_len;
        ld_flags = meta_flags;
        ld_time = meta_time;
        ld_status = prb_pkg::STATUS_OK;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer, pointers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active_slots <= prb_pkg::ACTIVE_RESET;
      write_slot <= '0;
      read_slot <= '0;
      write_offset <= '0;
    end else if (cfg_we) begin
      active_slots <= cfg_data;
      write_slot <= '0;
      read_slot <= '0;
      write_offset <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == prb_pkg::OP_WRITE) begin
              res_status <= wr_status;
              state <= S_RESULT;
              if (end_of_packet) begin
                if (full_now) begin
                  read_slot <= rs_adv;
                end
                write_slot <= ws_adv;
                write_offset <= '0;
              end else begin
                write_offset <= wo_after;
              end
            end else if (empty_now) begin
              res_status <= prb_pkg::STATUS_EMPTY;
              state <= S_RESULT;
            end else begin
              cur_slot <= read_slot;
              read_slot <= rs_adv;
              capacity <= read_capacity;
              state <= S_META;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_META: begin
          rd_idx <= '0;
          if (too_small) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_STREAM;
          end
        end
        S_STREAM: begin
          if (out_free) begin
            if (stream_last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + BIDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload, fill fields taken from the updated pointers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= ld_byte;
      out_byte_valid <= ld_bvalid;
      last_of_run <= ld_last;
      out_length <= prb_pkg::LEN_W'(ld_len);
      out_flags <= ld_flags;
      out_time <= ld_time;
      status <= ld_status;
      fill_percent <= pct_prod[prb_pkg::RECIP_SHIFT +: prb_pkg::PCT_W];
      ring_empty <= empty_now;
      ring_full <= full_now;
    end
  end

endmodule

[hdl/prb_checker.sv]
// Port-level checker for the packet ring buffer core, with its bind.
// Depends on prb_pkg and packet_ring_buffer_core.
module prb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input logic [prb_pkg::ACTIVE_W-1:0]  cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          operation,
  input logic [7:0]                    in_byte,
  input logic                          in_byte_valid,
  input logic                          end_of_packet,
  input logic [31:0]                   packet_flags,
  input logic signed [63:0]            packet_time,
  input logic [15:0]                   read_capacity,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    out_byte,
  input logic                          out_byte_valid,
  input logic                          last_of_run,
  input logic [prb_pkg::LEN_W-1:0]     out_length,
  input logic [31:0]                   out_flags,
  input logic signed [63:0]            out_time,
  input prb_pkg::status_t              status,
  input logic [prb_pkg::PCT_W-1:0]     fill_percent,
  input logic                          ring_empty,
  input logic                          ring_full
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(last_of_run))
    else $error("result changed while stalled");

  // Empty and full never show together
  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ring_empty && ring_full))
    else $error("ring both empty and full");

  // An empty ring reports zero fill
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && ring_empty |-> fill_percent == '0)
    else $error("nonzero fill on empty ring");

  // Data bytes only come with status ok and a nonzero length
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte_valid |-> status == prb_pkg::STATUS_OK && out_length != '0)
    else $error("data byte with bad status or length");

  // An empty-ring read is a single result on an empty ring
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == prb_pkg::STATUS_EMPTY |->
      ring_empty && last_of_run && !out_byte_valid)
    else $error("malformed empty result");

endmodule

bind packet_ring_buffer_core prb_checker u_prb_checker (.*);
